@@ hdl/lgbs_pkg.sv @@
package lgbs_pkg;

    // Serial link framing bytes
    localparam logic [7:0] SYNC_CMD    = 8'hF8;
    localparam logic [7:0] SYNC_DATA   = 8'hFA;
    localparam logic [7:0] ADDR_CMD    = 8'h80;
    localparam logic [7:0] NIBBLE_MASK = 8'hF0;

    // Pixels held in one buffer word
    localparam int PIX_PER_WORD = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 3'd3;

    // Configuration reset values
    localparam logic [7:0] RST_X_ORIGIN     = 8'd0;
    localparam logic [6:0] RST_Y_ORIGIN     = 7'd0;
    localparam logic [7:0] RST_BLOCK_WIDTH  = 8'd128;
    localparam logic [6:0] RST_BLOCK_HEIGHT = 7'd64;

    // Transfer within one word write
    localparam logic [1:0] XFER_VERT  = 2'd0;
    localparam logic [1:0] XFER_HORIZ = 2'd1;
    localparam logic [1:0] XFER_HI    = 2'd2;
    localparam logic [1:0] XFER_LO    = 2'd3;

    // Byte within one transfer
    localparam logic [1:0] PH_SYNC = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // One classified word write, handed from front to back
    typedef struct packed {
        logic [7:0]  vert_cmd;
        logic [7:0]  horiz_cmd;
        logic [15:0] word;
    } gdram_cmd_t;

endpackage

@@ hdl/lgbs_front.sv @@
module lgbs_front
    import lgbs_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic [5:0]           pixel_row,
    input  logic [2:0]           word_column,
    input  logic [15:0]          pixel_word,
    output logic                 hit,
    output gdram_cmd_t           cmd
);

    localparam int XW            = 10;
    localparam int WORDS_PER_ROW = SCREEN_WIDTH / PIX_PER_WORD;
    localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;

    logic [7:0]    x_origin_reg;
    logic [6:0]    y_origin_reg;
    logic [7:0]    block_width_reg;
    logic [6:0]    block_height_reg;

    logic [XW-1:0] x_eff;
    logic [XW-1:0] w_raw;
    logic [XW-1:0] w_eff;
    logic [XW-1:0] span;
    logic [XW-1:0] last_px;
    logic [5:0]    first_col;
    logic [5:0]    last_col;
    logic [5:0]    col_ext;
    logic [7:0]    row_ext;
    logic [7:0]    y_start;
    logic [7:0]    y_end;
    logic          width_ok;
    logic          row_ok;
    logic          col_ok;
    logic          bottom;
    logic [7:0]    vert;
    logic [7:0]    horiz;

    // Hold rectangle registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg     <= RST_X_ORIGIN;
            y_origin_reg     <= RST_Y_ORIGIN;
            block_width_reg  <= RST_BLOCK_WIDTH;
            block_height_reg <= RST_BLOCK_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_X_ORIGIN:     x_origin_reg     <= cfg_data;
                CFG_Y_ORIGIN:     y_origin_reg     <= cfg_data[6:0];
                CFG_BLOCK_WIDTH:  block_width_reg  <= cfg_data;
                CFG_BLOCK_HEIGHT: block_height_reg <= cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    // Clip the rectangle horizontally to the screen
    always_comb
    begin
        x_eff = {2'b00, x_origin_reg};
        if (x_eff > XW'(SCREEN_WIDTH - 1))
            x_eff = '0;
        w_raw = {2'b00, block_width_reg};
        span  = x_eff + w_raw;
        if (span > XW'(SCREEN_WIDTH))
            w_eff = XW'(SCREEN_WIDTH) - x_eff;
        else
            w_eff = w_raw;
        width_ok  = (w_eff != '0);
        last_px   = x_eff + w_eff - XW'(1);
        first_col = x_eff[XW-1:4];
        last_col  = last_px[XW-1:4];
    end

    // Classify the word against the rectangle
    always_comb
    begin
        col_ext = {3'b000, word_column};
        row_ext = {2'b00, pixel_row};
        y_start = {1'b0, y_origin_reg};
        y_end   = {1'b0, y_origin_reg} + {1'b0, block_height_reg};
        row_ok  = (row_ext >= y_start) && (row_ext < y_end)
                  && (row_ext < 8'(SCREEN_HEIGHT));
        col_ok  = (col_ext >= first_col) && (col_ext <= last_col)
                  && (col_ext < 6'(WORDS_PER_ROW));
        hit     = width_ok && row_ok && col_ok;
    end

    // Map bottom-half rows onto the second address bank
    always_comb
    begin
        bottom = (row_ext >= 8'(HALF_HEIGHT));
        if (bottom)
        begin
            vert  = row_ext - 8'(HALF_HEIGHT);
            horiz = {2'b00, col_ext} + 8'(WORDS_PER_ROW);
        end
        else
        begin
            vert  = row_ext;
            horiz = {2'b00, col_ext};
        end
        cmd.vert_cmd  = ADDR_CMD | vert;
        cmd.horiz_cmd = ADDR_CMD | horiz;
        cmd.word      = pixel_word;
    end

endmodule

@@ hdl/lgbs_queue.sv @@
module lgbs_queue
    import lgbs_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  gdram_cmd_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output logic       rd_valid,
    output gdram_cmd_t rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gdram_cmd_t    entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Advance pointers with explicit wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // Writes never land while full, reads never while empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> (count_reg == CW'(DEPTH)) || (count_reg == CW'(DEPTH - 1)))
        else $error("queue count grew past depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count missed a write");

endmodule

@@ hdl/lgbs_back.sv @@
module lgbs_back
    import lgbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  gdram_cmd_t q_data,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] serial_byte,
    output logic       frame_start,
    output logic       last_of_run
);

    logic       busy_reg;
    logic       busy_next;
    logic [1:0] xfer_reg;
    logic [1:0] xfer_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    gdram_cmd_t item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_start_reg;
    logic       out_last_reg;

    logic       pop_ok;
    logic       advance;
    logic       last_step;
    logic [7:0] cur_data;
    logic [7:0] cur_sync;
    logic [7:0] cur_byte;

    assign pop_ok    = pop && out_valid_reg;
    assign advance   = busy_reg && (!out_valid_reg || pop_ok);
    assign last_step = (xfer_reg == XFER_LO) && (phase_reg == PH_LOW);
    assign q_pop     = q_valid && (!busy_reg || (advance && last_step));

    // Pick the byte of the current transfer
    always_comb
    begin
        case (xfer_reg)
            XFER_VERT:  cur_data = item_reg.vert_cmd;
            XFER_HORIZ: cur_data = item_reg.horiz_cmd;
            XFER_HI:    cur_data = item_reg.word[15:8];
            XFER_LO:    cur_data = item_reg.word[7:0];
            default:    cur_data = item_reg.word[7:0];
        endcase
        if ((xfer_reg == XFER_VERT) || (xfer_reg == XFER_HORIZ))
            cur_sync = SYNC_CMD;
        else
            cur_sync = SYNC_DATA;
        case (phase_reg)
            PH_SYNC: cur_byte = cur_sync;
            PH_HIGH: cur_byte = cur_data & NIBBLE_MASK;
            PH_LOW:  cur_byte = {cur_data[3:0], 4'h0};
            default: cur_byte = cur_sync;
        endcase
    end

    // Step through twelve bytes, load the next word on the last one or when idle
    always_comb
    begin
        busy_next      = busy_reg;
        xfer_next      = xfer_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (pop_ok)
            out_valid_next = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (phase_reg == PH_LOW)
            begin
                phase_next = PH_SYNC;
                xfer_next  = xfer_reg + 2'd1;
            end
            else
            begin
                phase_next = phase_reg + 2'd1;
            end
            if (last_step)
                busy_next = 1'b0;
        end
        if (q_pop)
        begin
            busy_next  = 1'b1;
            xfer_next  = XFER_VERT;
            phase_next = PH_SYNC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            xfer_reg      <= XFER_VERT;
            phase_reg     <= PH_SYNC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            xfer_reg      <= xfer_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_data;
        if (advance)
        begin
            out_byte_reg  <= cur_byte;
            out_start_reg <= (phase_reg == PH_SYNC);
            out_last_reg  <= last_step;
        end
    end

    assign empty       = !out_valid_reg;
    assign serial_byte = out_byte_reg;
    assign frame_start = out_start_reg;
    assign last_of_run = out_last_reg;

    a_sync_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_start_reg)
            |-> ((out_byte_reg == SYNC_CMD) || (out_byte_reg == SYNC_DATA)))
        else $error("frame start without a sync byte");

    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> ((xfer_reg == XFER_VERT) && (phase_reg == PH_SYNC)))
        else $error("counters not rewound while idle");

    a_last_not_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> !out_start_reg)
        else $error("last byte flagged as frame start");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (phase_reg != 2'd3))
        else $error("phase counter ran past the low nibble");

endmodule

@@ hdl/lcd_gdram_block_serializer.sv @@
// Graphics-RAM block writer for a serial-link display controller.
//
// Input channel (push/full): one frame buffer word per transaction with its
// pixel_row and word_column. Words inside the configured rectangle are
// queued; words outside it are accepted and dropped without output.
// Result channel (empty/pop): twelve serial bytes per queued word: four
// transfers (vertical address, horizontal address, data high, data low),
// each a sync byte flagged by frame_start, then two nibble bytes; the
// twelfth byte carries last_of_run.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while the block is idle. Unknown indexes are ignored.
// When the path is idle, an accepted word passes a queue entry, the item
// register and the byte register before its first byte is on the result
// ports. Throughput: one byte per cycle while the receiver pops, set by the
// byte serializer; a two-entry queue lets new words be taken while bytes go out.
// A receiver stall holds the current byte and backs up into the queue,
// raising full once both entries are taken.
// Reset clears the queue and output stage and restores the rectangle to
// the full screen.
module lcd_gdram_block_serializer
    import lgbs_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [5:0]           pixel_row,
    input  logic [2:0]           word_column,
    input  logic [15:0]          pixel_word,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           serial_byte,
    output logic                 frame_start,
    output logic                 last_of_run
);

    logic       hit;
    gdram_cmd_t front_cmd;
    logic       q_wr;
    logic       q_valid;
    logic       q_pop;
    gdram_cmd_t q_data;

    assign cfg_ready = 1'b1;
    assign q_wr      = push && !full && hit;

    lgbs_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_row   (pixel_row),
        .word_column (word_column),
        .pixel_word  (pixel_word),
        .hit         (hit),
        .cmd         (front_cmd)
    );

    lgbs_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_wr),
        .wr_data  (front_cmd),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    lgbs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .serial_byte (serial_byte),
        .frame_start (frame_start),
        .last_of_run (last_of_run)
    );

endmodule

@@ dv/lcd_gdram_block_serializer_tb.sv @@
module lcd_gdram_block_serializer_tb
    import lgbs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_W   = 128;
    localparam int SCREEN_H   = 64;
    localparam int HALF_CLK   = 4;
    localparam int RESET_LEN  = 10;
    localparam int DRAIN_TAIL = 6;
    localparam int HOLD_LEN   = 150;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 20;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum {ROW_CFG, ROW_WORD, ROW_HIT, ROW_MISS} row_kind_t;

    // Config rows: a = index, b = data. Word rows: a = row, b = column, c = word,
    // v/h = vertical and horizontal commands where typed in.
    typedef struct {
        row_kind_t  kind;
        int         a;
        int         b;
        int         c;
        logic [7:0] v;
        logic [7:0] h;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       last;
    } link_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [5:0]           pixel_row = '0;
    logic [2:0]           word_column = '0;
    logic [15:0]          pixel_word = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [7:0]           serial_byte;
    logic                 frame_start;
    logic                 last_of_run;

    // Shadow copy of the rectangle registers
    logic [7:0] sh_x = RST_X_ORIGIN;
    logic [6:0] sh_y = RST_Y_ORIGIN;
    logic [7:0] sh_w = RST_BLOCK_WIDTH;
    logic [6:0] sh_h = RST_BLOCK_HEIGHT;

    link_byte_t link_bytes_due [$];
    link_byte_t want_byte;
    stim_row_t  dir_rows [$];
    int         mismatches = 0;
    int         snd_idle_pct = 0;
    int         rcv_stall_pct = 0;
    logic       hold_on = 1'b0;
    event       hold_kick;

    lcd_gdram_block_serializer #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .pixel_row   (pixel_row),
        .word_column (word_column),
        .pixel_word  (pixel_word),
        .empty       (empty),
        .pop         (pop),
        .serial_byte (serial_byte),
        .frame_start (frame_start),
        .last_of_run (last_of_run)
    );

    always
    begin
        #(HALF_CLK) clk = 1'b1;
        #(HALF_CLK) clk = 1'b0;
    end

    // One three-byte transfer: sync, high nibble, low nibble
    function automatic void frame_transfer(logic [7:0] sync, logic [7:0] b, logic last);
        link_byte_t lb;
        lb = '{sync, 1'b1, 1'b0};
        link_bytes_due.push_back(lb);
        lb = '{b & NIBBLE_MASK, 1'b0, 1'b0};
        link_bytes_due.push_back(lb);
        lb = '{{b[3:0], 4'h0}, 1'b0, last};
        link_bytes_due.push_back(lb);
    endfunction

    // Twelve bytes that write one word at a given address
    function automatic void frame_word_write(logic [7:0] vcmd, logic [7:0] hcmd,
                                             logic [15:0] w);
        frame_transfer(SYNC_CMD, vcmd, 1'b0);
        frame_transfer(SYNC_CMD, hcmd, 1'b0);
        frame_transfer(SYNC_DATA, w[15:8], 1'b0);
        frame_transfer(SYNC_DATA, w[7:0], 1'b1);
    endfunction

    // Decide whether a word falls in the rectangle and queue its bytes
    function automatic void predict_gdram_write(logic [5:0] r, logic [2:0] c,
                                                logic [15:0] w);
        int x;
        int wd;
        int col_lo;
        int col_hi;
        int vert;
        int horiz;
        x = sh_x;
        wd = sh_w;
        if (x > SCREEN_W - 1)
            x = 0;
        if (x + wd > SCREEN_W)
            wd = SCREEN_W - x;
        if (wd == 0)
            return;
        if (r < sh_y || int'(r) >= int'(sh_y) + int'(sh_h) || r >= SCREEN_H)
            return;
        col_lo = x / PIX_PER_WORD;
        col_hi = (x + wd - 1) / PIX_PER_WORD;
        if (c < col_lo || c > col_hi || c >= SCREEN_W / PIX_PER_WORD)
            return;
        // Bottom half of the screen sits to the right in controller memory
        if (r < SCREEN_H / 2)
        begin
            vert = r;
            horiz = c;
        end
        else
        begin
            vert = r - SCREEN_H / 2;
            horiz = c + SCREEN_W / PIX_PER_WORD;
        end
        frame_word_write(ADDR_CMD | 8'(vert), ADDR_CMD | 8'(horiz), w);
    endfunction

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_X_ORIGIN:     sh_x = val;
            CFG_Y_ORIGIN:     sh_y = val[6:0];
            CFG_BLOCK_WIDTH:  sh_w = val;
            CFG_BLOCK_HEIGHT: sh_h = val[6:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one word and hold it until the block takes it
    task automatic send_word(row_kind_t kind, logic [5:0] r, logic [2:0] c,
                             logic [15:0] w, logic [7:0] vcmd, logic [7:0] hcmd);
        push        <= 1'b1;
        pixel_row   <= r;
        word_column <= c;
        pixel_word  <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        case (kind)
            ROW_HIT:  frame_word_write(vcmd, hcmd, w);
            ROW_MISS: ;
            default:  predict_gdram_write(r, c, w);
        endcase
    endtask

    // Stop offering and wait for every expected byte, plus a short tail
    task automatic drain();
        push <= 1'b0;
        while (link_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL)
            @(posedge clk);
    endtask

    // Load a new rectangle, extremes included
    task automatic pick_config();
        logic [7:0] nx;
        logic [7:0] ny;
        logic [7:0] nw;
        logic [7:0] nh;
        case ($urandom_range(0, 5))
            0:
            begin
                nx = RST_X_ORIGIN;
                ny = 8'(RST_Y_ORIGIN);
                nw = RST_BLOCK_WIDTH;
                nh = 8'(RST_BLOCK_HEIGHT);
            end
            1:
            begin
                nx = 8'($urandom_range(128, 255));
                ny = 8'd0;
                nw = 8'd255;
                nh = 8'd127;
            end
            2:
            begin
                nx = 8'($urandom);
                ny = 8'($urandom);
                nw = 8'($urandom);
                nh = 8'($urandom);
            end
            default:
            begin
                nx = 8'($urandom_range(0, 127));
                ny = 8'($urandom_range(0, 48));
                nw = 8'($urandom_range(1, 128));
                nh = 8'($urandom_range(8, 64));
            end
        endcase
        write_reg(CFG_X_ORIGIN, nx);
        write_reg(CFG_Y_ORIGIN, ny);
        write_reg(CFG_BLOCK_WIDTH, nw);
        write_reg(CFG_BLOCK_HEIGHT, nh);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 8'($urandom));
    endtask

    // Hold the receiver off for a fixed stretch when kicked
    initial
    begin
        forever
        begin
            @(hold_kick);
            hold_on <= 1'b1;
            repeat (HOLD_LEN)
                @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // Check each accepted byte against the oldest expectation, then drive pop
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (link_bytes_due.size() == 0)
            begin
                $error("unexpected byte: serial_byte %02h frame_start %0b last_of_run %0b",
                       serial_byte, frame_start, last_of_run);
                mismatches++;
            end
            else
            begin
                want_byte = link_bytes_due.pop_front();
                if (serial_byte !== want_byte.data)
                begin
                    $error("serial_byte: expected %02h, got %02h", want_byte.data, serial_byte);
                    mismatches++;
                end
                if (frame_start !== want_byte.start)
                begin
                    $error("frame_start: expected %0b, got %0b", want_byte.start, frame_start);
                    mismatches++;
                end
                if (last_of_run !== want_byte.last)
                begin
                    $error("last_of_run: expected %0b, got %0b", want_byte.last, last_of_run);
                    mismatches++;
                end
            end
        end
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= !hold_on && ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    initial
    begin
        stim_row_t  cur;
        logic [5:0] r;
        logic [2:0] c;
        int         ylo;
        int         yhi;
        int         xo;

        dir_rows = '{
            // Full screen after reset: corners and both halves
            '{ROW_HIT,  0,  0, 16'h0000, 8'h80, 8'h80},
            '{ROW_HIT,  63, 7, 16'hFFFF, 8'h9F, 8'h8F},
            '{ROW_HIT,  31, 3, 16'hA5C3, 8'h9F, 8'h83},
            '{ROW_HIT,  32, 4, 16'h5A3C, 8'h80, 8'h8C},
            '{ROW_WORD, 17, 5, 16'h1234, 8'h00, 8'h00},
            // Origin off screen folds to zero, width clipped to the screen
            '{ROW_CFG,  CFG_X_ORIGIN,    200, 0, 8'h00, 8'h00},
            '{ROW_CFG,  CFG_BLOCK_WIDTH, 255, 0, 8'h00, 8'h00},
            '{ROW_HIT,  5,  7, 16'h8001, 8'h85, 8'h87},
            // Rightmost column, one pixel wide after clipping
            '{ROW_CFG,  CFG_X_ORIGIN,    127, 0, 8'h00, 8'h00},
            '{ROW_HIT,  40, 7, 16'h7FFE, 8'h88, 8'h8F},
            '{ROW_MISS, 40, 6, 16'h1111, 8'h00, 8'h00},
            // Zero width writes nothing
            '{ROW_CFG,  CFG_BLOCK_WIDTH, 0,   0, 8'h00, 8'h00},
            '{ROW_MISS, 0,  7, 16'hFFFF, 8'h00, 8'h00},
            // Word columns one to three only
            '{ROW_CFG,  CFG_X_ORIGIN,    16,  0, 8'h00, 8'h00},
            '{ROW_CFG,  CFG_BLOCK_WIDTH, 40,  0, 8'h00, 8'h00},
            '{ROW_MISS, 10, 0, 16'h2222, 8'h00, 8'h00},
            '{ROW_HIT,  10, 1, 16'h3333, 8'h8A, 8'h81},
            '{ROW_HIT,  10, 3, 16'h4444, 8'h8A, 8'h83},
            '{ROW_MISS, 10, 4, 16'h5555, 8'h00, 8'h00},
            // Row band edges
            '{ROW_CFG,  CFG_Y_ORIGIN,     20, 0, 8'h00, 8'h00},
            '{ROW_CFG,  CFG_BLOCK_HEIGHT, 10, 0, 8'h00, 8'h00},
            '{ROW_MISS, 19, 2, 16'h6666, 8'h00, 8'h00},
            '{ROW_HIT,  20, 2, 16'h7777, 8'h94, 8'h82},
            '{ROW_HIT,  29, 2, 16'h8888, 8'h9D, 8'h82},
            '{ROW_MISS, 30, 2, 16'h9999, 8'h00, 8'h00},
            // Band entirely below the screen
            '{ROW_CFG,  CFG_Y_ORIGIN,     255, 0, 8'h00, 8'h00},
            '{ROW_CFG,  CFG_BLOCK_HEIGHT, 255, 0, 8'h00, 8'h00},
            '{ROW_MISS, 63, 2, 16'hAAAA, 8'h00, 8'h00},
            // Band running past the bottom edge
            '{ROW_CFG,  CFG_Y_ORIGIN,     60,  0, 8'h00, 8'h00},
            '{ROW_CFG,  CFG_BLOCK_HEIGHT, 127, 0, 8'h00, 8'h00},
            '{ROW_HIT,  63, 3, 16'hC3A5, 8'h9F, 8'h8B},
            '{ROW_MISS, 59, 3, 16'hBBBB, 8'h00, 8'h00},
            // Writes to unused indexes change nothing
            '{ROW_CFG,  CFG_SPARE_HI, 0, 0, 8'h00, 8'h00},
            '{ROW_CFG,  CFG_SPARE_LO, 0, 0, 8'h00, 8'h00},
            '{ROW_HIT,  60, 1, 16'hCCCC, 8'h9C, 8'h89},
            '{ROW_MISS, 61, 0, 16'hDDDD, 8'h00, 8'h00},
            // Back to the full screen
            '{ROW_CFG,  CFG_X_ORIGIN,     0,   0, 8'h00, 8'h00},
            '{ROW_CFG,  CFG_Y_ORIGIN,     0,   0, 8'h00, 8'h00},
            '{ROW_CFG,  CFG_BLOCK_WIDTH,  128, 0, 8'h00, 8'h00},
            '{ROW_CFG,  CFG_BLOCK_HEIGHT, 64,  0, 8'h00, 8'h00},
            '{ROW_WORD, 33, 0, 16'h0F0F, 8'h00, 8'h00},
            '{ROW_WORD, 47, 5, 16'hFF00, 8'h00, 8'h00}
        };

        // Hold reset, then release it once
        repeat (RESET_LEN)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_rows[i])
        begin
            cur = dir_rows[i];
            if (cur.kind == ROW_CFG)
            begin
                drain();
                write_reg(CFG_IDX_W'(cur.a), 8'(cur.b));
            end
            else
                send_word(cur.kind, 6'(cur.a), 3'(cur.b), 16'(cur.c), cur.v, cur.h);
        end

        // Random phases, each with a fresh rectangle and its own idling mix
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            pick_config();
            case (p % 4)
                0:
                begin
                    snd_idle_pct = 0;
                    rcv_stall_pct = 0;
                end
                1:
                begin
                    snd_idle_pct = 53;
                    rcv_stall_pct = 0;
                end
                2:
                begin
                    snd_idle_pct = 0;
                    rcv_stall_pct = 53;
                end
                default:
                begin
                    snd_idle_pct = 37;
                    rcv_stall_pct = 37;
                end
            endcase
            // Back up the result side so the input stalls
            if (p % 4 == 0)
                -> hold_kick;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                while ($urandom_range(0, 99) < snd_idle_pct)
                begin
                    push <= 1'b0;
                    @(posedge clk);
                end
                r = 6'($urandom);
                c = 3'($urandom);
                // Aim most words inside the rectangle
                if ($urandom_range(0, 3) != 0)
                begin
                    ylo = sh_y;
                    yhi = sh_y + sh_h - 1;
                    if (yhi > SCREEN_H - 1)
                        yhi = SCREEN_H - 1;
                    if (sh_h != 0 && ylo <= SCREEN_H - 1)
                        r = 6'($urandom_range(ylo, yhi));
                    xo = (sh_x > SCREEN_W - 1) ? 0 : sh_x;
                    c = 3'($urandom_range(xo / PIX_PER_WORD, SCREEN_W / PIX_PER_WORD - 1));
                end
                send_word(ROW_WORD, r, c, 16'($urandom), 8'h00, 8'h00);
            end
        end

        // Let everything come out with the receiver always ready
        rcv_stall_pct = 0;
        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
